### src/coc_pkg.sv
package coc_pkg;

   // Field widths
   localparam int NumW     = 16;
   localparam int LenW     = 16;
   localparam int ErrW     = 6;
   localparam int PresentW = 19;
   localparam int SeenW    = 13;
   localparam int RuleLenW = 11;
   localparam int PresIdxW = 5;
   localparam int SeenIdxW = 4;

   // Error mask bit positions
   localparam int ErrRepeat      = 0;
   localparam int ErrCritRepeat  = 1;
   localparam int ErrLength      = 2;
   localparam int ErrCritLength  = 3;
   localparam int ErrUnknown     = 4;
   localparam int ErrCritUnknown = 5;

   // Result of looking up one option number
   typedef struct packed {
      logic                found;
      logic [PresIdxW-1:0] pres_idx;
      logic [RuleLenW-1:0] min_len;
      logic [RuleLenW-1:0] max_len;
      logic                once;
      logic [SeenIdxW-1:0] seen_idx;
   } rule_type;

   function automatic rule_type mk_rule(input int pidx, input int mn, input int mx,
                                        input logic once, input int sidx);
      rule_type r;
      r.found    = 1'b1;
      r.pres_idx = PresIdxW'(pidx);
      r.min_len  = RuleLenW'(mn);
      r.max_len  = RuleLenW'(mx);
      r.once     = once;
      r.seen_idx = SeenIdxW'(sidx);
      return r;
   endfunction

   // Option rule table, keyed by option number
   function automatic rule_type lookup_rule(input logic [NumW-1:0] num);
      rule_type r;
      r = '0;
      case (num)
         16'd1:   r = mk_rule(0,  0, 8,    1'b0, 0);   // If-Match
         16'd3:   r = mk_rule(1,  1, 255,  1'b1, 0);   // Uri-Host
         16'd4:   r = mk_rule(2,  1, 8,    1'b0, 0);   // ETag
         16'd5:   r = mk_rule(3,  0, 0,    1'b1, 1);   // If-None-Match
         16'd6:   r = mk_rule(4,  0, 3,    1'b1, 2);   // Observe
         16'd7:   r = mk_rule(5,  0, 2,    1'b1, 3);   // Uri-Port
         16'd8:   r = mk_rule(6,  0, 255,  1'b0, 0);   // Location-Path
         16'd11:  r = mk_rule(7,  0, 255,  1'b0, 0);   // Uri-Path
         16'd12:  r = mk_rule(8,  0, 2,    1'b1, 4);   // Content-Format
         16'd14:  r = mk_rule(9,  0, 4,    1'b1, 5);   // Max-Age
         16'd15:  r = mk_rule(10, 0, 255,  1'b0, 0);   // Uri-Query
         16'd17:  r = mk_rule(11, 0, 2,    1'b1, 6);   // Accept
         16'd20:  r = mk_rule(12, 0, 255,  1'b0, 0);   // Location-Query
         16'd35:  r = mk_rule(13, 1, 1034, 1'b1, 7);   // Proxy-Uri
         16'd39:  r = mk_rule(14, 1, 255,  1'b1, 8);   // Proxy-Scheme
         16'd60:  r = mk_rule(15, 0, 4,    1'b1, 9);   // Size1
         16'd28:  r = mk_rule(16, 0, 4,    1'b1, 10);  // Size2
         16'd27:  r = mk_rule(17, 0, 3,    1'b1, 11);  // Block1
         16'd23:  r = mk_rule(18, 0, 3,    1'b1, 12);  // Block2
         default: r = '0;
      endcase
      return r;
   endfunction

   // Map the non-repeatable seen set onto present-mask positions
   function automatic logic [PresentW-1:0] seen_to_present(input logic [SeenW-1:0] s);
      logic [PresentW-1:0] p;
      p     = '0;
      p[1]  = s[0];
      p[3]  = s[1];
      p[4]  = s[2];
      p[5]  = s[3];
      p[8]  = s[4];
      p[9]  = s[5];
      p[11] = s[6];
      p[13] = s[7];
      p[14] = s[8];
      p[15] = s[9];
      p[16] = s[10];
      p[17] = s[11];
      p[18] = s[12];
      return p;
   endfunction

endpackage

### src/coap_option_checker_core.sv
// Channel  | Ports                                                  | Direction
// ---------+--------------------------------------------------------+----------
// request  | req_valid req_ready req_option_number req_value_length | in
//          | req_last_option                                        |
// response | rsp_valid rsp_ready rsp_error_mask rsp_present_mask    | out
//          | rsp_message_done                                       |
//
// One beat per cycle sustained while the response side is ready; a request beat is
// captured in the input register and its result in the result register, with one table
// lookup and one seen-set update between them.
// Synchronous active-high reset clears the valid bits and the per-message state.
// A stalled response holds both stages; the request side is ready whenever the
// input register is empty or moving on.
module coap_option_checker_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [coc_pkg::NumW-1:0]          req_option_number,
   input  logic [coc_pkg::LenW-1:0]          req_value_length,
   input  logic                              req_last_option,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [coc_pkg::ErrW-1:0]          rsp_error_mask,
   output logic [coc_pkg::PresentW-1:0]      rsp_present_mask,
   output logic                              rsp_message_done
);

   // Input register
   logic                         s1_valid_ff, s1_valid_in;
   logic [coc_pkg::NumW-1:0]     s1_num_ff;
   logic [coc_pkg::LenW-1:0]     s1_len_ff;
   logic                         s1_last_ff;

   // Result register
   logic                         out_valid_ff, out_valid_in;
   logic [coc_pkg::ErrW-1:0]     out_err_ff, out_err_in;
   logic [coc_pkg::PresentW-1:0] out_pres_ff, out_pres_in;
   logic                         out_done_ff;

   // Per-message state
   logic [coc_pkg::SeenW-1:0]    seen_ff, seen_in;
   logic [coc_pkg::ErrW-1:0]     errs_ff, errs_in;
   logic [coc_pkg::PresentW-1:0] pres_ff, pres_in;

   logic                         out_free;
   logic                         s1_adv;
   logic                         req_take;
   coc_pkg::rule_type            rule;
   logic                         crit;
   logic                         len_bad;
   logic                         rep_hit;
   logic [coc_pkg::SeenW-1:0]    seen_bit;
   logic [coc_pkg::ErrW-1:0]     new_errs;

   // Handshake flow
   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   // Check one option against its rule
   always_comb begin
      rule     = coc_pkg::lookup_rule(s1_num_ff);
      crit     = s1_num_ff[0];
      len_bad  = (s1_len_ff < {{(coc_pkg::LenW-coc_pkg::RuleLenW){1'b0}}, rule.min_len}) ||
                 (s1_len_ff > {{(coc_pkg::LenW-coc_pkg::RuleLenW){1'b0}}, rule.max_len});
      seen_bit = coc_pkg::SeenW'(1) << rule.seen_idx;
      rep_hit  = rule.once && ((seen_ff & seen_bit) != '0);
      new_errs = '0;
      if (rule.found) begin
         if (len_bad) begin
            new_errs[crit ? coc_pkg::ErrCritLength : coc_pkg::ErrLength] = 1'b1;
         end
         if (rep_hit) begin
            new_errs[crit ? coc_pkg::ErrCritRepeat : coc_pkg::ErrRepeat] = 1'b1;
         end
      end else begin
         new_errs[crit ? coc_pkg::ErrCritUnknown : coc_pkg::ErrUnknown] = 1'b1;
      end
      out_err_in  = errs_ff | new_errs;
      out_pres_in = pres_ff;
      if (rule.found) begin
         out_pres_in[rule.pres_idx] = 1'b1;
      end
   end

   // Next state: advance the message state, clear at its end
   always_comb begin
      s1_valid_in  = req_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      seen_in      = seen_ff;
      errs_in      = errs_ff;
      pres_in      = pres_ff;
      if (s1_adv) begin
         if (s1_last_ff) begin
            seen_in = '0;
            errs_in = '0;
            pres_in = '0;
         end else begin
            if (rule.found && rule.once) begin
               seen_in = seen_ff | seen_bit;
            end
            errs_in = out_err_in;
            pres_in = out_pres_in;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         seen_ff      <= '0;
         errs_ff      <= '0;
         pres_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         seen_ff      <= seen_in;
         errs_ff      <= errs_in;
         pres_ff      <= pres_in;
      end
   end

   // Payload registers: load input beat, hold result while stalled
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_num_ff  <= req_option_number;
         s1_len_ff  <= req_value_length;
         s1_last_ff <= req_last_option;
      end
      if (s1_adv) begin
         out_err_ff  <= out_err_in;
         out_pres_ff <= out_pres_in;
         out_done_ff <= s1_last_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_error_mask   = out_err_ff;
   assign rsp_present_mask = out_pres_ff;
   assign rsp_message_done = out_done_ff;

`ifndef ASSERT_OFF
   // End of message leaves the state clear
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_last_ff |=> seen_ff == '0 && errs_ff == '0 && pres_ff == '0)
      else $error("message state not cleared after last option");

   // Every seen non-repeatable option is also marked present
   a_seen_in_present: assert property (@(posedge clock) disable iff (reset)
      (coc_pkg::seen_to_present(seen_ff) & ~pres_ff) == '0)
      else $error("seen option missing from present mask");

   // Mid-message, present and error sets only grow
   a_monotone: assert property (@(posedge clock) disable iff (reset)
      s1_adv && !s1_last_ff |=> ((pres_ff & $past(pres_ff)) == $past(pres_ff)) &&
                                ((errs_ff & $past(errs_ff)) == $past(errs_ff)))
      else $error("message state lost bits mid-message");

   // An unknown option never adds a present bit
   a_unknown_no_present: assert property (@(posedge clock) disable iff (reset)
      s1_adv && !rule.found |=> out_pres_ff == $past(pres_ff))
      else $error("unknown option set a present bit");
`endif

endmodule
